/* hw/rtl/ffra_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the first-fit range allocator.
// No dependencies; every other file of the allocator imports this package.
package ffra_pkg;

   localparam int LIVE_SLOTS  = 64;
   localparam int FREE_SLOTS  = 65;
   localparam int OFFSET_BITS = 16;
   localparam int LEN_BITS    = OFFSET_BITS + 1;
   localparam int SCAN_LEN    = (FREE_SLOTS > LIVE_SLOTS) ? FREE_SLOTS : LIVE_SLOTS;
   localparam int CNT_BITS    = $clog2(SCAN_LEN + 1);
   localparam int FCNT_BITS   = $clog2(FREE_SLOTS + 1);
   localparam int LCNT_BITS   = $clog2(LIVE_SLOTS + 1);
   localparam logic [LEN_BITS-1:0] POOL_MAX = LEN_BITS'(1) << OFFSET_BITS;

   typedef enum logic [1:0] {
      REQ_RESERVE = 2'd0,
      REQ_RELEASE = 2'd1,
      REQ_CLEAR   = 2'd2,
      REQ_NONE    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FIT    = 2'd1,
      ST_NOT_ALLOC = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_APPLY,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                   valid;
      logic [OFFSET_BITS-1:0] start;
      logic [LEN_BITS-1:0]    len;
   } range_entry_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

endpackage

/* hw/rtl/ffra_cell.sv */
`timescale 1ns / 1ps
// One cell of a ring of range entries: holds a start, a length and a valid bit.
// Depends on ffra_pkg for the entry and control types.
module ffra_cell import ffra_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cell_ctl_type    ctl,
   input  range_entry_type init_entry,
   input  range_entry_type din,
   output range_entry_type dout
);

   range_entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         entry_ff <= init_entry;
      end else if (ctl.shift) begin
         entry_ff <= din;
      end
   end

   assign dout = entry_ff;

endmodule

/* hw/rtl/first_fit_range_allocator.sv */
`timescale 1ns / 1ps
// Top level of the first-fit range allocator: two rings of cells and their control.
// Depends on ffra_pkg and ffra_cell.
// A successful reserve or release answers after a scan pass, a decision, an update pass
// and finish; a failing one skips the update pass, a zero-size reserve both passes.
// Other requests go straight to finish; the next request is taken once an answer is presented.
// Synchronous reset gives one free range of 65536 bytes and no live allocations.
module first_fit_range_allocator import ffra_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // alloc_size[16:0], release_offset[32:17], zero pad
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[1:0], granted_offset[17:2], freed_size[34:18]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int FLAST = FREE_SLOTS - 1;
   localparam int LLAST = LIVE_SLOTS - 1;
   localparam logic [2:0] ADDR_POOL = 3'd0;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [LEN_BITS-1:0] pool_ff, pool_in;
   logic [1:0] rtype_ff, rtype_in;
   logic [LEN_BITS-1:0] size_ff, size_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic fit_ff, fit_in;
   logic [OFFSET_BITS-1:0] best_start_ff, best_start_in;
   logic [LEN_BITS-1:0] best_len_ff, best_len_in;
   logic prev_ff, prev_in;
   logic [OFFSET_BITS-1:0] prev_start_ff, prev_start_in;
   logic nxt_ff, nxt_in;
   logic [OFFSET_BITS-1:0] nxt_start_ff, nxt_start_in;
   logic [LEN_BITS-1:0] nxt_len_ff, nxt_len_in;
   logic hit_ff, hit_in;
   logic [LEN_BITS-1:0] hit_len_ff, hit_len_in;
   logic pt_ff, pt_in, nt_ff, nt_in;
   logic ok_ff, ok_in;
   logic fins_ff, fins_in, lins_ff, lins_in;
   logic [FCNT_BITS-1:0] fcount_ff, fcount_in;
   logic [LCNT_BITS-1:0] lcount_ff, lcount_in;
   status_type status_ff, status_in;
   logic [OFFSET_BITS-1:0] granted_ff, granted_in;
   logic [LEN_BITS-1:0] freed_ff, freed_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [OFFSET_BITS-1:0] rsp_granted_ff, rsp_granted_in;
   logic [LEN_BITS-1:0] rsp_freed_ff, rsp_freed_in;

   logic req_fire, cfg_write, do_clear, fshift, lshift, applying, finish_load;
   logic [LEN_BITS-1:0] pool_len;
   logic [LEN_BITS-1:0] req_size;
   logic [OFFSET_BITS-1:0] req_off;
   range_entry_type f_q [FREE_SLOTS];
   range_entry_type l_q [LIVE_SLOTS];
   range_entry_type f_tail, l_tail, f_head, l_head, f_init0, zero_entry;
   cell_ctl_type fctl, lctl;
   logic [LEN_BITS-1:0] head_end;
   logic [LEN_BITS-1:0] rel_end;

   assign req_size = req_tdata[16:0];
   assign req_off  = req_tdata[32:17];
   assign req_fire = req_tvalid && req_tready;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (csr_paddr == ADDR_POOL);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_POOL) ? {{(32-LEN_BITS){1'b0}}, pool_ff} : 32'd0;
   assign pool_len = (pool_ff > POOL_MAX) ? POOL_MAX : pool_ff;
   assign zero_entry = '0;
   assign f_init0 = reset
      ? range_entry_type'{valid: 1'b1, start: '0, len: POOL_MAX}
      : range_entry_type'{valid: (pool_len != '0), start: '0, len: pool_len};

   // Free and live rings.
   generate
      for (genvar i = 0; i < FREE_SLOTS; i++) begin : g_free
         ffra_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (fctl),
            .init_entry((i == 0) ? f_init0 : zero_entry),
            .din       ((i == FLAST) ? f_tail : f_q[(i + 1) % FREE_SLOTS]),
            .dout      (f_q[i])
         );
      end
      for (genvar j = 0; j < LIVE_SLOTS; j++) begin : g_live
         ffra_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (lctl),
            .init_entry(zero_entry),
            .din       ((j == LLAST) ? l_tail : l_q[(j + 1) % LIVE_SLOTS]),
            .dout      (l_q[j])
         );
      end
   endgenerate

   assign f_head = f_q[0];
   assign l_head = l_q[0];
   assign head_end = {1'b0, f_head.start} + f_head.len;
   assign rel_end  = {1'b0, off_ff} + hit_len_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if ((req_tuser == REQ_RESERVE && req_size != '0) || req_tuser == REQ_RELEASE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            if (cnt_ff == CNT_BITS'(SCAN_LEN - 1)) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = ok_in ? S_APPLY : S_FINISH;
         end
         S_APPLY: begin
            if (cnt_ff == CNT_BITS'(SCAN_LEN - 1)) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_tready  = (state_ff == S_IDLE);
      do_clear    = req_fire && (req_tuser == REQ_CLEAR);
      applying    = (state_ff == S_APPLY);
      fshift      = (state_ff == S_SCAN || applying) && (cnt_ff < CNT_BITS'(FREE_SLOTS));
      lshift      = (state_ff == S_SCAN || applying) && (cnt_ff < CNT_BITS'(LIVE_SLOTS));
      finish_load = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);
      fctl        = '{shift: fshift, clear: do_clear};
      lctl        = '{shift: lshift, clear: do_clear};
   end

   // Ring tail updates.
   always_comb begin
      f_tail = f_head;
      l_tail = l_head;
      if (applying && rtype_ff == REQ_RESERVE) begin
         if (f_head.valid && f_head.start == best_start_ff) begin
            f_tail.start = f_head.start + size_ff[OFFSET_BITS-1:0];
            f_tail.len   = f_head.len - size_ff;
            f_tail.valid = (f_head.len != size_ff);
         end
         if (!l_head.valid && !lins_ff) begin
            l_tail = '{valid: 1'b1, start: best_start_ff, len: size_ff};
         end
      end else if (applying && rtype_ff == REQ_RELEASE) begin
         if (pt_ff && f_head.valid && f_head.start == prev_start_ff) begin
            f_tail.len = f_head.len + hit_len_ff + (nt_ff ? nxt_len_ff : '0);
         end else if (nt_ff && f_head.valid && f_head.start == nxt_start_ff) begin
            if (pt_ff) begin
               f_tail.valid = 1'b0;
            end else begin
               f_tail.start = off_ff;
               f_tail.len   = f_head.len + hit_len_ff;
            end
         end else if (!pt_ff && !nt_ff && !f_head.valid && !fins_ff) begin
            f_tail = '{valid: 1'b1, start: off_ff, len: hit_len_ff};
         end
         if (l_head.valid && l_head.start == off_ff) begin
            l_tail.valid = 1'b0;
         end
      end
   end

   // Datapath registers.
   always_comb begin
      cnt_in = cnt_ff;
      pool_in = cfg_write ? csr_pwdata[LEN_BITS-1:0] : pool_ff;
      rtype_in = rtype_ff;
      size_in = size_ff;
      off_in = off_ff;
      fit_in = fit_ff;
      best_start_in = best_start_ff;
      best_len_in = best_len_ff;
      prev_in = prev_ff;
      prev_start_in = prev_start_ff;
      nxt_in = nxt_ff;
      nxt_start_in = nxt_start_ff;
      nxt_len_in = nxt_len_ff;
      hit_in = hit_ff;
      hit_len_in = hit_len_ff;
      pt_in = pt_ff;
      nt_in = nt_ff;
      ok_in = ok_ff;
      fins_in = fins_ff;
      lins_in = lins_ff;
      fcount_in = fcount_ff;
      lcount_in = lcount_ff;
      status_in = status_ff;
      granted_in = granted_ff;
      freed_in = freed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_freed_in = rsp_freed_ff;

      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_fire) begin
               rtype_in = req_tuser;
               size_in = req_size;
               off_in = req_off;
               fit_in = 1'b0;
               prev_in = 1'b0;
               nxt_in = 1'b0;
               hit_in = 1'b0;
               fins_in = 1'b0;
               lins_in = 1'b0;
               ok_in = 1'b0;
               granted_in = '0;
               freed_in = '0;
               status_in = (req_tuser == REQ_RESERVE) ? ST_NO_FIT : ST_OK;
               if (req_tuser == REQ_CLEAR) begin
                  fcount_in = FCNT_BITS'(pool_len != '0);
                  lcount_in = '0;
               end
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (fshift && f_head.valid) begin
               if (f_head.len >= size_ff && (!fit_ff || f_head.start < best_start_ff)) begin
                  fit_in = 1'b1;
                  best_start_in = f_head.start;
                  best_len_in = f_head.len;
               end
               if (head_end == {1'b0, off_ff}) begin
                  prev_in = 1'b1;
                  prev_start_in = f_head.start;
               end
               if (f_head.start > off_ff && (!nxt_ff || f_head.start < nxt_start_ff)) begin
                  nxt_in = 1'b1;
                  nxt_start_in = f_head.start;
                  nxt_len_in = f_head.len;
               end
            end
            if (lshift && l_head.valid && l_head.start == off_ff) begin
               hit_in = 1'b1;
               hit_len_in = l_head.len;
            end
         end
         S_DECIDE: begin
            cnt_in = '0;
            pt_in = prev_ff;
            nt_in = nxt_ff && ({1'b0, nxt_start_ff} == rel_end);
            if (rtype_ff == REQ_RESERVE) begin
               if (!fit_ff) begin
                  status_in = ST_NO_FIT;
               end else if (lcount_ff == LCNT_BITS'(LIVE_SLOTS)) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_OK;
                  ok_in = 1'b1;
                  granted_in = best_start_ff;
                  lcount_in = lcount_ff + 1'b1;
                  if (best_len_ff == size_ff) fcount_in = fcount_ff - 1'b1;
               end
            end else begin
               if (!hit_ff) begin
                  status_in = ST_NOT_ALLOC;
               end else if (!prev_ff && !nt_in && fcount_ff == FCNT_BITS'(FREE_SLOTS)) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_OK;
                  ok_in = 1'b1;
                  freed_in = hit_len_ff;
                  lcount_in = lcount_ff - 1'b1;
                  if (prev_ff && nt_in) begin
                     fcount_in = fcount_ff - 1'b1;
                  end else if (!prev_ff && !nt_in) begin
                     fcount_in = fcount_ff + 1'b1;
                  end
               end
            end
         end
         S_APPLY: begin
            cnt_in = cnt_ff + 1'b1;
            if (fshift && !f_head.valid) fins_in = 1'b1;
            if (lshift && !l_head.valid) lins_in = 1'b1;
         end
         S_FINISH: begin
            if (finish_load) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_granted_in = granted_ff;
               rsp_freed_in = freed_ff;
            end
         end
         default: cnt_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         pool_ff <= POOL_MAX;
         fcount_ff <= FCNT_BITS'(1);
         lcount_ff <= '0;
         rsp_valid_ff <= 1'b0;
         fins_ff <= 1'b0;
         lins_ff <= 1'b0;
         ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         pool_ff <= pool_in;
         fcount_ff <= fcount_in;
         lcount_ff <= lcount_in;
         rsp_valid_ff <= rsp_valid_in;
         fins_ff <= fins_in;
         lins_ff <= lins_in;
         ok_ff <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      rtype_ff <= rtype_in;
      size_ff <= size_in;
      off_ff <= off_in;
      fit_ff <= fit_in;
      best_start_ff <= best_start_in;
      best_len_ff <= best_len_in;
      prev_ff <= prev_in;
      prev_start_ff <= prev_start_in;
      nxt_ff <= nxt_in;
      nxt_start_ff <= nxt_start_in;
      nxt_len_ff <= nxt_len_in;
      hit_ff <= hit_in;
      hit_len_ff <= hit_len_in;
      pt_ff <= pt_in;
      nt_ff <= nt_in;
      status_ff <= status_in;
      granted_ff <= granted_in;
      freed_ff <= freed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_freed_ff <= rsp_freed_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_freed_ff, rsp_granted_ff, rsp_status_ff};

   a_fcount: assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= FCNT_BITS'(FREE_SLOTS))
      else $error("Free range count exceeds the ring size.");
   a_lcount: assert property (@(posedge clock) disable iff (reset)
      lcount_ff <= LCNT_BITS'(LIVE_SLOTS))
      else $error("Live allocation count exceeds the table size.");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("Block stayed idle after a request transfer.");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_APPLY) |-> cnt_ff < CNT_BITS'(SCAN_LEN))
      else $error("Ring pass counter ran past the ring length.");
   a_load: assert property (@(posedge clock) disable iff (reset)
      finish_load |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("Finished result was not presented.");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_range_allocator: directed and random reserve, release,
// clear and no-op requests with random stalls on both streams and pool size changes.
// Depends on ffra_pkg and the allocator RTL; a scoreboard class predicts every response.
module tb;
   import ffra_pkg::*;

   typedef struct {
      status_type  status;
      logic [15:0] granted;
      logic [16:0] freed;
   } alloc_rsp_type;

   class alloc_scoreboard;
      int unsigned   pool_bytes;
      int unsigned   free_start[FREE_SLOTS];
      int unsigned   free_len[FREE_SLOTS];
      int unsigned   free_count;
      int unsigned   live_start[LIVE_SLOTS];
      int unsigned   live_len[LIVE_SLOTS];
      bit            live_valid[LIVE_SLOTS];
      alloc_rsp_type pending[$];
      int            mismatches;

      function void set_pool(int unsigned value);
         pool_bytes = value & 32'h1FFFF;
      endfunction

      function void clear_pool();
         int unsigned len;
         len = (pool_bytes > POOL_MAX) ? POOL_MAX : pool_bytes;
         for (int k = 0; k < FREE_SLOTS; k++) begin
            free_start[k] = 0;
            free_len[k] = 0;
         end
         for (int k = 0; k < LIVE_SLOTS; k++) begin
            live_valid[k] = 0;
            live_start[k] = 0;
            live_len[k] = 0;
         end
         free_len[0] = len;
         free_count = (len != 0) ? 1 : 0;
      endfunction

      function void drop_range(int unsigned i);
         for (int unsigned k = i; k + 1 < free_count; k++) begin
            free_start[k] = free_start[k + 1];
            free_len[k] = free_len[k + 1];
         end
         free_count--;
         free_start[free_count] = 0;
         free_len[free_count] = 0;
      endfunction

      function status_type reserve(int unsigned size, output int unsigned granted);
         int unsigned i;
         int unsigned slot;
         granted = 0;
         if (size == 0) return ST_NO_FIT;
         for (i = 0; i < free_count; i++)
            if (free_len[i] >= size) break;
         if (i >= free_count) return ST_NO_FIT;
         for (slot = 0; slot < LIVE_SLOTS; slot++)
            if (!live_valid[slot]) break;
         if (slot >= LIVE_SLOTS) return ST_FULL;
         granted = free_start[i];
         live_valid[slot] = 1;
         live_start[slot] = free_start[i];
         live_len[slot] = size;
         free_start[i] += size;
         free_len[i] -= size;
         if (free_len[i] == 0) drop_range(i);
         return ST_OK;
      endfunction

      function status_type release_range(int unsigned off, output int unsigned freed);
         int unsigned slot;
         int unsigned p;
         int unsigned size;
         bit          prev_touch;
         bit          next_touch;
         freed = 0;
         for (slot = 0; slot < LIVE_SLOTS; slot++)
            if (live_valid[slot] && live_start[slot] == off) break;
         if (slot >= LIVE_SLOTS) return ST_NOT_ALLOC;
         size = live_len[slot];
         for (p = 0; p < free_count; p++)
            if (free_start[p] > off) break;
         prev_touch = p > 0 && free_start[p - 1] + free_len[p - 1] == off;
         next_touch = p < free_count && off + size == free_start[p];
         if (prev_touch && next_touch) begin
            free_len[p - 1] += size + free_len[p];
            drop_range(p);
         end else if (prev_touch) begin
            free_len[p - 1] += size;
         end else if (next_touch) begin
            free_start[p] = off;
            free_len[p] += size;
         end else begin
            if (free_count >= FREE_SLOTS) return ST_FULL;
            for (int unsigned k = free_count; k > p; k--) begin
               free_start[k] = free_start[k - 1];
               free_len[k] = free_len[k - 1];
            end
            free_start[p] = off;
            free_len[p] = size;
            free_count++;
         end
         live_valid[slot] = 0;
         live_start[slot] = 0;
         live_len[slot] = 0;
         freed = size;
         return ST_OK;
      endfunction

      function void note_request(req_kind_type kind, int unsigned size, int unsigned off);
         alloc_rsp_type rsp;
         int unsigned   granted;
         int unsigned   freed;
         granted = 0;
         freed = 0;
         rsp.status = ST_OK;
         case (kind)
            REQ_RESERVE: rsp.status = reserve(size, granted);
            REQ_RELEASE: rsp.status = release_range(off, freed);
            REQ_CLEAR:   clear_pool();
            default:     rsp.status = ST_OK;
         endcase
         rsp.granted = granted[15:0];
         rsp.freed = freed[16:0];
         pending = {pending, rsp};
      endfunction

      function void check_result(logic [1:0] status, logic [15:0] granted, logic [16:0] freed);
         alloc_rsp_type exp_rsp;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response: status %0d offset %0d freed %0d",
                        status, granted, freed);
            return;
         end
         exp_rsp = pending.pop_front();
         if (status !== exp_rsp.status || granted !== exp_rsp.granted ||
             freed !== exp_rsp.freed) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                        exp_rsp.status, exp_rsp.granted, exp_rsp.freed,
                        status, granted, freed);
         end
      endfunction

      function int live_offset();
         int picks[$];
         for (int k = 0; k < LIVE_SLOTS; k++)
            if (live_valid[k]) picks = {picks, int'(live_start[k])};
         if (picks.size() == 0) return -1;
         return picks[$urandom_range(0, picks.size() - 1)];
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   alloc_scoreboard sb;
   int              hold_cycles;
   bit              no_gaps;
   int unsigned     cycle_count = 0;

   first_fit_range_allocator u_top (.*);

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[1:0], rsp_tdata[17:2], rsp_tdata[34:18]);

   initial begin
      int wait_cycles;
      rsp_tready = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         wait_cycles = no_gaps ? 0 : $urandom_range(0, 3);
         if (wait_cycles > 0) begin
            rsp_tready <= 0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_request(req_kind_type kind, int unsigned size, int unsigned off);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {7'd0, off[15:0], size[16:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, size, off);
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   task automatic write_pool_size(int unsigned value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= 3'd0;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      sb.set_pool(value);
   endtask

   task automatic random_request(int reserve_pct);
      int unsigned pick;
      int unsigned size;
      int          off;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         send_request(REQ_CLEAR, $urandom_range(0, 17'h1FFFF), $urandom_range(0, 16'hFFFF));
      end else if (pick < 4) begin
         send_request(REQ_NONE, $urandom_range(0, 17'h1FFFF), $urandom_range(0, 16'hFFFF));
      end else if (pick < 4 + reserve_pct) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) size = $urandom_range(1, 64);
         else if (pick < 90) size = $urandom_range(1, 4096);
         else if (pick < 95) size = $urandom_range(0, 17'h1FFFF);
         else size = (pick < 97) ? 0 : 65536;
         send_request(REQ_RESERVE, size, $urandom_range(0, 16'hFFFF));
      end else begin
         off = sb.live_offset();
         if (off < 0 || $urandom_range(0, 9) < 3) off = $urandom_range(0, 16'hFFFF);
         send_request(REQ_RELEASE, $urandom_range(0, 17'h1FFFF), off);
      end
   endtask

   initial begin
      int unsigned pools[7];
      sb = new();
      sb.set_pool(65536);
      sb.clear_pool();
      hold_cycles = 0;
      no_gaps = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = REQ_NONE;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_request(REQ_RESERVE, 0, 0);
      send_request(REQ_RESERVE, 17'h1FFFF, 16'hFFFF);
      send_request(REQ_RESERVE, 65536, 0);
      send_request(REQ_RESERVE, 1, 0);
      send_request(REQ_RELEASE, 0, 0);
      send_request(REQ_RELEASE, 0, 16'hFFFF);
      send_request(REQ_NONE, 17'h1FFFF, 16'hFFFF);
      send_request(REQ_RESERVE, 100, 0);
      send_request(REQ_RESERVE, 200, 0);
      send_request(REQ_RESERVE, 300, 0);
      send_request(REQ_RELEASE, 0, 100);
      send_request(REQ_RELEASE, 0, 0);
      send_request(REQ_RELEASE, 0, 300);
      send_request(REQ_RELEASE, 0, 300);
      send_request(REQ_RESERVE, 65535, 0);
      send_request(REQ_RESERVE, 1, 0);
      send_request(REQ_RELEASE, 0, 65535);
      send_request(REQ_CLEAR, 0, 0);

      pools = '{65536, 1, 300, 131071, 0, 4096, 65536};
      pools[5] = $urandom_range(2, 65536);
      for (int ph = 0; ph < 7; ph++) begin
         wait_idle();
         write_pool_size(pools[ph]);
         no_gaps = (ph == 3);
         send_request(REQ_CLEAR, 0, 0);
         if (ph == 1) hold_cycles = 600;
         for (int n = 0; n < 210; n++)
            random_request((ph == 0 || ph == 6) ? 75 : 55);
      end
      wait_idle();

      if (sb.pending.size() == 0 && sb.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

/* first_fit_range_allocator.f */
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_cell.sv
hw/rtl/first_fit_range_allocator.sv
tb/tb.sv
